// ----- sv/multicore_task_list_scheduler_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the multicore task list scheduler
// Shared immediate-style wrappers around concurrent properties.
// ----------------------------------------------------------------------------
`ifndef MULTICORE_TASK_LIST_SCHEDULER_MACROS_SVH
`define MULTICORE_TASK_LIST_SCHEDULER_MACROS_SVH

// Antecedent holds in a cycle, consequent holds in the same cycle.
`define MTLS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent holds in a cycle, consequent holds in the next cycle.
`define MTLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/mtls_pkg.sv -----
// ----------------------------------------------------------------------------
// mtls_pkg
// Types and constants shared by the task scheduler controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mtls_pkg;

	localparam int PCT_SCALE = 100;
	localparam int LOAD_W    = 7;

	typedef enum logic [1:0] {
		KIND_FREE,
		KIND_READY,
		KIND_DELAYED,
		KIND_WAITING
	} kind_t;

	typedef enum logic [2:0] {
		OP_CREATE,
		OP_DELAY,
		OP_WAIT,
		OP_RELEASE,
		OP_TICK,
		OP_YIELD
	} op_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_NO_SLOT,
		ST_ZERO,
		ST_NO_MATCH
	} status_t;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_SET_STATUS,
		CMD_CREATE,
		CMD_PARK,
		CMD_UNLINK,
		CMD_APPEND,
		CMD_RESCHED,
		CMD_REL_INIT,
		CMD_SC_INC,
		CMD_SC_LOAD,
		CMD_STEP,
		CMD_MARK_HIT,
		CMD_TICK,
		CMD_SAVE_NEXT,
		CMD_COUNT_REL,
		CMD_ADVANCE,
		CMD_DIV_START,
		CMD_EMIT
	} cmd_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_C_APPEND,
		S_P_UNLINK,
		S_P_APPEND,
		S_RESCHED,
		S_REL_CHECK,
		S_REL_CMP,
		S_REL_NEXT,
		S_R_UNLINK,
		S_R_APPEND,
		S_T_CHECK,
		S_T_CMP,
		S_T_UNLINK,
		S_T_APPEND,
		S_T_ADV,
		S_DIV,
		S_DIV_WAIT,
		S_FIN
	} state_t;

	typedef struct packed {
		cmd_t    cmd;
		kind_t   kind;
		status_t status;
	} ctrl_cmd_t;

	typedef struct packed {
		logic       core_ok;
		logic [2:0] op;
		logic       value_zero;
		logic       count_full;
		logic       run_valid;
		logic       cur_valid;
		logic       sc_done;
		logic       sc_skip;
		logic       msg_match;
		logic       tick_due;
		logic       div_done;
		logic       out_free;
	} dp_stat_t;

	// List number of a non-free kind.
	function automatic logic [1:0] list_of(kind_t k);
		return 2'(k) - 2'd1;
	endfunction

endpackage

`default_nettype wire

// ----- sv/mtls_div.sv -----
// ----------------------------------------------------------------------------
// mtls_div
// Restoring divider for the load figure, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mtls_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [15:0]                 rate,
	input  wire logic [15:0]                 snap,
	output logic                             done,
	output logic [mtls_pkg::LOAD_W-1:0]      quot
);
	import mtls_pkg::*;

	logic        busy_q;
	logic [2:0]  bit_q;
	logic [22:0] rem_q;
	logic [15:0] den_q;
	logic [LOAD_W-1:0] quot_q;
	logic [22:0] num;
	logic [22:0] trial;

	assign num   = 23'(rate - snap) * 23'(PCT_SCALE);
	assign trial = {7'd0, den_q} << bit_q;
	assign done  = !busy_q;
	assign quot  = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			quot_q <= '0;
		end else if (start) begin
			quot_q <= '0;
			if (rate == 16'd0 || snap >= rate) begin
				busy_q <= 1'b0;
			end else begin
				busy_q <= 1'b1;
			end
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				quot_q[bit_q] <= 1'b1;
			end
			if (bit_q == 3'd0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= rate;
			bit_q <= 3'(LOAD_W - 1);
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
			end
			bit_q <= bit_q - 3'd1;
		end
	end

endmodule

`default_nettype wire

// ----- sv/mtls_datapath.sv -----
// ----------------------------------------------------------------------------
// mtls_datapath
// Task lists, per-core counters, slot memories and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtls_datapath #(
	parameter int NUM_CORES      = 4,
	parameter int TASKS_PER_CORE = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mtls_pkg::ctrl_cmd_t  cmd,
	output mtls_pkg::dp_stat_t        stat,
	input  wire logic [2:0]           s_tuser,
	input  wire logic [47:0]          s_tdata,
	input  wire logic                 tick_rate_we,
	input  wire logic [15:0]          tick_rate_wdata,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [31:0]               m_tdata
);
	import mtls_pkg::*;

	localparam int CW  = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
	localparam int SI  = $clog2(TASKS_PER_CORE);
	localparam int LW  = $clog2(TASKS_PER_CORE + 1);
	localparam int AW  = CW + SI;
	localparam int SCW = $clog2(NUM_CORES + 1);
	localparam logic [LW-1:0] NO_LINK = LW'(TASKS_PER_CORE);

	// Item registers.
	logic [2:0]    op_q;
	logic [CW-1:0] core_q;
	logic          core_ok_q;
	logic [31:0]   value_q;
	logic          idle_req_q;

	// Walk registers.
	logic [CW-1:0]  wc_q;
	logic [LW-1:0]  cur_q;
	logic [LW-1:0]  nxt_q;
	logic [SCW-1:0] sc_q;

	// Result registers.
	status_t       status_q;
	logic [SI-1:0] slot_out_q;
	logic [CW-1:0] core_out_q;
	logic [LW-1:0] rel_q;

	// Per-core state.
	logic [LW-1:0] run_q   [NUM_CORES];
	logic [LW-1:0] idle_q  [NUM_CORES];
	logic [31:0]   tick_q  [NUM_CORES];
	logic [15:0]   icnt_q  [NUM_CORES];
	logic [15:0]   frame_q [NUM_CORES];
	logic [15:0]   snap_q  [NUM_CORES];
	logic [LW-1:0] count_q [NUM_CORES];
	logic [LW-1:0] head_q  [NUM_CORES][3];
	logic [LW-1:0] tail_q  [NUM_CORES][3];

	// Per-slot links.
	kind_t         kind_q [NUM_CORES][TASKS_PER_CORE];
	logic [LW-1:0] next_q [NUM_CORES][TASKS_PER_CORE];
	logic [LW-1:0] prev_q [NUM_CORES][TASKS_PER_CORE];

	logic [15:0] rate_q;

	// Slot data memories.
	logic [31:0] rtick_mem [2**AW];
	logic [31:0] msg_mem   [2**AW];
	logic [31:0] rtick_rd_s1;
	logic [31:0] msg_rd_s1;

	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;

	logic [LW-1:0]  r;
	logic           r_valid;
	logic [SI-1:0]  r_idx;
	logic [SI-1:0]  cur_idx;
	kind_t          u_kind;
	logic [LW-1:0]  u_prev;
	logic [LW-1:0]  u_next;
	logic [LW-1:0]  a_tail;
	logic [LW-1:0]  r_next;
	logic           idle_now;
	logic [15:0]    idle_new;
	logic [CW-1:0]  sc_core;
	logic [AW-1:0]  rd_addr;
	logic [AW-1:0]  wr_addr;
	logic           div_done;
	logic [LOAD_W-1:0] quot;
	logic [15:0]    div_snap;
	logic [31:0]    result;

	assign r        = run_q[core_q];
	assign r_valid  = (r != NO_LINK);
	assign r_idx    = r[SI-1:0];
	assign cur_idx  = cur_q[SI-1:0];
	assign u_kind   = kind_q[wc_q][cur_idx];
	assign u_prev   = prev_q[wc_q][cur_idx];
	assign u_next   = next_q[wc_q][cur_idx];
	assign a_tail   = tail_q[wc_q][list_of(cmd.kind)];
	assign r_next   = next_q[core_q][r_idx];
	assign sc_core  = CW'(sc_q);
	assign rd_addr  = {wc_q, cur_idx};
	assign wr_addr  = {core_q, r_idx};
	assign div_snap = core_ok_q ? snap_q[core_q] : 16'd0;

	// A tick is idle when the idle task runs, or when no task runs and none is idle.
	assign idle_now = r_valid ? (r == idle_q[core_q]) : (idle_q[core_q] == NO_LINK);
	assign idle_new = icnt_q[core_q] +
		16'((idle_now && icnt_q[core_q] != 16'hFFFF) ? 1 : 0);

	assign stat.core_ok    = core_ok_q;
	assign stat.op         = op_q;
	assign stat.value_zero = (value_q == 32'd0);
	assign stat.count_full = (count_q[core_q] >= NO_LINK);
	assign stat.run_valid  = r_valid;
	assign stat.cur_valid  = (cur_q != NO_LINK);
	assign stat.sc_done    = (sc_q == SCW'(NUM_CORES));
	assign stat.sc_skip    = (sc_q == SCW'(core_q));
	assign stat.msg_match  = (msg_rd_s1 == value_q);
	assign stat.tick_due   = (tick_q[wc_q] >= rtick_rd_s1);
	assign stat.div_done   = div_done;
	assign stat.out_free   = !m_tvalid_q || m_tready;

	mtls_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.cmd == CMD_DIV_START),
		.rate  (rate_q),
		.snap  (div_snap),
		.done  (div_done),
		.quot  (quot)
	);

	always_comb begin
		result = '0;
		if (core_ok_q) begin
			result[1:0]   = status_q;
			result[4:2]   = 3'(slot_out_q);
			result[6:5]   = 2'(core_out_q);
			result[9:7]   = r_valid ? 3'(r_idx) : 3'd0;
			result[10]    = r_valid;
			result[14:11] = 4'(count_q[core_q]);
			result[21:15] = quot;
			result[25:22] = 4'(rel_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			rate_q     <= 16'd1000;
			status_q   <= ST_OK;
			rel_q      <= '0;
			sc_q       <= '0;
			cur_q      <= NO_LINK;
			for (int c = 0; c < NUM_CORES; c++) begin
				run_q[c]   <= NO_LINK;
				idle_q[c]  <= NO_LINK;
				tick_q[c]  <= '0;
				icnt_q[c]  <= '0;
				frame_q[c] <= '0;
				snap_q[c]  <= '0;
				count_q[c] <= '0;
				for (int l = 0; l < 3; l++) begin
					head_q[c][l] <= NO_LINK;
					tail_q[c][l] <= NO_LINK;
				end
				for (int s = 0; s < TASKS_PER_CORE; s++) begin
					kind_q[c][s] <= KIND_FREE;
					next_q[c][s] <= NO_LINK;
					prev_q[c][s] <= NO_LINK;
				end
			end
		end else begin
			if (tick_rate_we) begin
				rate_q <= tick_rate_wdata;
			end
			if (cmd.cmd == CMD_EMIT) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (cmd.cmd)
				CMD_LOAD: begin
					status_q <= ST_OK;
					rel_q    <= '0;
				end
				CMD_SET_STATUS: status_q <= cmd.status;
				CMD_CREATE: begin
					count_q[core_q] <= count_q[core_q] + LW'(1);
					if (!r_valid) begin
						run_q[core_q] <= count_q[core_q];
					end
					if (idle_req_q) begin
						idle_q[core_q] <= count_q[core_q];
					end
					cur_q <= count_q[core_q];
				end
				CMD_PARK: cur_q <= r;
				CMD_UNLINK: begin
					if (u_kind != KIND_FREE) begin
						if (u_prev != NO_LINK) begin
							next_q[wc_q][u_prev[SI-1:0]] <= u_next;
						end else begin
							head_q[wc_q][list_of(u_kind)] <= u_next;
						end
						if (u_next != NO_LINK) begin
							prev_q[wc_q][u_next[SI-1:0]] <= u_prev;
						end else begin
							tail_q[wc_q][list_of(u_kind)] <= u_prev;
						end
						next_q[wc_q][cur_idx] <= NO_LINK;
						prev_q[wc_q][cur_idx] <= NO_LINK;
					end
				end
				CMD_APPEND: begin
					if (a_tail != NO_LINK) begin
						next_q[wc_q][a_tail[SI-1:0]] <= cur_q;
					end else begin
						head_q[wc_q][list_of(cmd.kind)] <= cur_q;
					end
					prev_q[wc_q][cur_idx]           <= a_tail;
					next_q[wc_q][cur_idx]           <= NO_LINK;
					tail_q[wc_q][list_of(cmd.kind)] <= cur_q;
					kind_q[wc_q][cur_idx]           <= cmd.kind;
				end
				CMD_RESCHED: begin
					if (r_valid && r_next != NO_LINK) begin
						run_q[core_q] <= r_next;
					end else begin
						run_q[core_q] <= head_q[core_q][list_of(KIND_READY)];
					end
				end
				CMD_REL_INIT: begin
					cur_q <= head_q[core_q][list_of(KIND_WAITING)];
					sc_q  <= '0;
				end
				CMD_SC_INC: sc_q <= sc_q + SCW'(1);
				CMD_SC_LOAD: begin
					cur_q <= head_q[sc_core][list_of(KIND_WAITING)];
					sc_q  <= sc_q + SCW'(1);
				end
				CMD_STEP: cur_q <= u_next;
				CMD_TICK: begin
					if (frame_q[core_q] >= rate_q) begin
						frame_q[core_q] <= '0;
						snap_q[core_q]  <= idle_new;
						icnt_q[core_q]  <= '0;
					end else begin
						frame_q[core_q] <= frame_q[core_q] + 16'd1;
						icnt_q[core_q]  <= idle_new;
					end
					tick_q[core_q] <= tick_q[core_q] + 32'd1;
					cur_q          <= head_q[core_q][list_of(KIND_DELAYED)];
				end
				CMD_COUNT_REL: rel_q <= rel_q + LW'(1);
				CMD_ADVANCE:   cur_q <= nxt_q;
				default: ;
			endcase
		end
	end

	// Item and walk payload registers.
	always_ff @(posedge clk) begin
		if (cmd.cmd == CMD_EMIT) begin
			m_tdata_q <= result;
		end
		unique case (cmd.cmd)
			CMD_LOAD: begin
				op_q       <= s_tuser;
				core_q     <= CW'(s_tdata[1:0]);
				core_ok_q  <= ({30'd0, s_tdata[1:0]} < 32'(NUM_CORES));
				value_q    <= s_tdata[33:2];
				idle_req_q <= s_tdata[42];
				slot_out_q <= '0;
				core_out_q <= '0;
			end
			CMD_CREATE: begin
				wc_q       <= core_q;
				slot_out_q <= count_q[core_q][SI-1:0];
			end
			CMD_PARK: begin
				wc_q       <= core_q;
				slot_out_q <= r_idx;
			end
			CMD_REL_INIT: wc_q <= core_q;
			CMD_SC_LOAD:  wc_q <= sc_core;
			CMD_MARK_HIT: begin
				slot_out_q <= cur_idx;
				core_out_q <= wc_q;
			end
			CMD_TICK:      wc_q  <= core_q;
			CMD_SAVE_NEXT: nxt_q <= u_next;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.cmd == CMD_PARK) begin
			if (op_q == OP_DELAY) begin
				rtick_mem[wr_addr] <= tick_q[core_q] + value_q;
			end else begin
				msg_mem[wr_addr] <= value_q;
			end
		end
		rtick_rd_s1 <= rtick_mem[rd_addr];
		msg_rd_s1   <= msg_mem[rd_addr];
	end

endmodule

`default_nettype wire

// ----- sv/mtls_ctrl.sv -----
// ----------------------------------------------------------------------------
// mtls_ctrl
// Sequencer that steps the datapath through each scheduler operation.
// ----------------------------------------------------------------------------
`default_nettype none

module mtls_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	input  wire mtls_pkg::dp_stat_t  stat,
	output mtls_pkg::ctrl_cmd_t      cmd,
	output logic                     in_ready
);
	import mtls_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.cmd    = CMD_NONE;
		cmd.kind   = KIND_READY;
		cmd.status = ST_OK;
		in_ready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (s_tvalid) begin
					cmd.cmd = CMD_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_DIV;
				if (stat.core_ok) begin
					unique case (stat.op) inside
						OP_CREATE: begin
							if (stat.count_full) begin
								cmd.cmd    = CMD_SET_STATUS;
								cmd.status = ST_NO_SLOT;
							end else begin
								cmd.cmd = CMD_CREATE;
								state_d = S_C_APPEND;
							end
						end
						OP_DELAY, OP_WAIT: begin
							if (stat.value_zero) begin
								cmd.cmd    = CMD_SET_STATUS;
								cmd.status = ST_ZERO;
							end else if (stat.run_valid) begin
								cmd.cmd = CMD_PARK;
								state_d = S_P_UNLINK;
							end
						end
						OP_RELEASE: begin
							if (stat.value_zero) begin
								cmd.cmd    = CMD_SET_STATUS;
								cmd.status = ST_ZERO;
							end else begin
								cmd.cmd = CMD_REL_INIT;
								state_d = S_REL_CHECK;
							end
						end
						OP_TICK: begin
							cmd.cmd = CMD_TICK;
							state_d = S_T_CHECK;
						end
						OP_YIELD: begin
							cmd.cmd = CMD_RESCHED;
						end
						default: ;
					endcase
				end
			end
			S_C_APPEND: begin
				cmd.cmd  = CMD_APPEND;
				cmd.kind = KIND_READY;
				state_d  = S_DIV;
			end
			S_P_UNLINK: begin
				cmd.cmd = CMD_UNLINK;
				state_d = S_P_APPEND;
			end
			S_P_APPEND: begin
				cmd.cmd  = CMD_APPEND;
				cmd.kind = (stat.op == OP_DELAY) ? KIND_DELAYED : KIND_WAITING;
				state_d  = S_RESCHED;
			end
			S_RESCHED: begin
				cmd.cmd = CMD_RESCHED;
				state_d = S_DIV;
			end
			S_REL_CHECK: begin
				state_d = stat.cur_valid ? S_REL_CMP : S_REL_NEXT;
			end
			S_REL_CMP: begin
				if (stat.msg_match) begin
					cmd.cmd = CMD_MARK_HIT;
					state_d = S_R_UNLINK;
				end else begin
					cmd.cmd = CMD_STEP;
					state_d = S_REL_CHECK;
				end
			end
			S_REL_NEXT: begin
				if (stat.sc_done) begin
					cmd.cmd    = CMD_SET_STATUS;
					cmd.status = ST_NO_MATCH;
					state_d    = S_DIV;
				end else if (stat.sc_skip) begin
					cmd.cmd = CMD_SC_INC;
				end else begin
					cmd.cmd = CMD_SC_LOAD;
					state_d = S_REL_CHECK;
				end
			end
			S_R_UNLINK: begin
				cmd.cmd = CMD_UNLINK;
				state_d = S_R_APPEND;
			end
			S_R_APPEND: begin
				cmd.cmd  = CMD_APPEND;
				cmd.kind = KIND_READY;
				state_d  = S_DIV;
			end
			S_T_CHECK: begin
				if (stat.cur_valid) begin
					cmd.cmd = CMD_SAVE_NEXT;
					state_d = S_T_CMP;
				end else begin
					state_d = S_RESCHED;
				end
			end
			S_T_CMP: begin
				if (stat.tick_due) begin
					cmd.cmd = CMD_COUNT_REL;
					state_d = S_T_UNLINK;
				end else begin
					cmd.cmd = CMD_ADVANCE;
					state_d = S_T_CHECK;
				end
			end
			S_T_UNLINK: begin
				cmd.cmd = CMD_UNLINK;
				state_d = S_T_APPEND;
			end
			S_T_APPEND: begin
				cmd.cmd  = CMD_APPEND;
				cmd.kind = KIND_READY;
				state_d  = S_T_ADV;
			end
			S_T_ADV: begin
				cmd.cmd = CMD_ADVANCE;
				state_d = S_T_CHECK;
			end
			S_DIV: begin
				cmd.cmd = CMD_DIV_START;
				state_d = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (stat.div_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.cmd = CMD_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/multicore_task_list_scheduler.sv -----
// ----------------------------------------------------------------------------
// multicore_task_list_scheduler
// Per-core round robin task scheduler with ready, delayed and waiting lists.
// ----------------------------------------------------------------------------
// Usage: each request item enters on the s_ channel, with the operation code
// on s_tuser and the core, value, priority and idle flag in s_tdata. Every
// request answers with exactly one result item on the m_ channel.
// The tick rate register is written through tick_rate_we and tick_rate_wdata
// and sets the ticks per load frame; the user must write it only while no
// request is in flight, as the block itself does not enforce this.
// Each item is sequenced step by step: a tick inspects every delayed task
// and makes each due one ready; a release compares the waiting tasks of
// each core it scans until one matches. The tail of every item is the load
// divider, which produces one quotient bit per cycle; when the rate is zero
// or the idle snapshot is no smaller than the rate, it finishes at once.
// Throughput is one item at a time: the sequencer walks the linked lists
// one slot per step over a single read port of the slot memories.
// Reset clears every list, counter and link at once; the register returns
// to 1000 and no clearing pass is needed. A stalled receiver holds the
// result in the output register; the next request is still taken and runs
// up to the point where its own result needs that register.
// ----------------------------------------------------------------------------
`default_nettype none

module multicore_task_list_scheduler #(
	parameter int NUM_CORES      = 4,
	parameter int TASKS_PER_CORE = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Request channel.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// core[1:0], value[33:2], priority_req[41:34], is_idle[42], zero above
	input  wire logic [47:0] s_tdata,
	// operation[2:0]
	input  wire logic [2:0]  s_tuser,
	// Result channel.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// status[1:0], task_slot[4:2], task_core[6:5], current_task[9:7],
	// current_valid[10], task_count[14:11], load_percent[21:15],
	// released_count[25:22], zero above
	output logic [31:0]      m_tdata,
	// Tick rate register write port.
	input  wire logic        tick_rate_we,
	input  wire logic [15:0] tick_rate_wdata
);
	import mtls_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// The controller only sequences; all scheduler state lives in the datapath.
	mtls_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.stat    (stat),
		.cmd     (cmd),
		.in_ready(s_tready)
	);

	// Priority is accepted but not stored; scheduling is round robin.
	mtls_datapath #(
		.NUM_CORES     (NUM_CORES),
		.TASKS_PER_CORE(TASKS_PER_CORE)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.s_tuser        (s_tuser),
		.s_tdata        (s_tdata),
		.tick_rate_we   (tick_rate_we),
		.tick_rate_wdata(tick_rate_wdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata)
	);

endmodule

`default_nettype wire

// ----- sv/mtls_checker.sv -----
// ----------------------------------------------------------------------------
// mtls_checker
// Port-level checks for the task scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multicore_task_list_scheduler_macros.svh"

module mtls_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);
	import mtls_pkg::*;

	// One request at a time: the input closes right after an item is taken.
	`MTLS_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second item early")

	`MTLS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result moved")

	// No running task means the reported current task is zero.
	`MTLS_ASSERT_SAME(a_idle_slot, m_tvalid && !m_tdata[10], m_tdata[9:7] == 3'd0, "slot, no task")

	`MTLS_ASSERT_SAME(a_load_range, m_tvalid, m_tdata[21:15] <= 7'd100, "load above one hundred")

	// A failed release names no slot and no core.
	`MTLS_ASSERT_SAME(a_nomatch, m_tvalid && m_tdata[1:0] == ST_NO_MATCH, m_tdata[6:2] == 5'd0, "miss")

endmodule

bind multicore_task_list_scheduler mtls_checker u_mtls_checker (.*);

`default_nettype wire

// ----- test/tb_multicore_task_list_scheduler.sv -----
// ----------------------------------------------------------------------------
// tb_multicore_task_list_scheduler
// Self-checking bench for the per-core task scheduler. A table of directed
// requests runs first, then three phases of random requests. Each phase has
// its own tick rate and its own idling on the request and result channels.
// Every result item is checked field by field against the expected fields of
// its directed row or against a scheduler model kept inside the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_multicore_task_list_scheduler;
	timeunit 1ns;
	timeprecision 1ps;
	import mtls_pkg::*;

	localparam int CORES = 4;
	localparam int SLOTS = 8;
	localparam int NO_LINK = SLOTS;
	localparam int PHASE_ITEMS = 550;
	localparam int STALL_LIMIT = 5000;

	// Result word, packed exactly as m_tdata: the last field sits in the lowest bits.
	typedef struct packed {
		logic [5:0] pad;
		logic [3:0] released;
		logic [6:0] load;
		logic [3:0] count;
		logic       cur_valid;
		logic [2:0] cur_task;
		logic [1:0] rel_core;
		logic [2:0] slot;
		status_t    status;
	} sched_result_t;

	typedef struct {
		logic [2:0]    op;
		logic [1:0]    core;
		logic [31:0]   value;
		logic [7:0]    prio;
		logic          idle;
		bit            typed;
		sched_result_t want;
	} request_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        tick_rate_we = 1'b0;
	logic [15:0] tick_rate_wdata = '0;

	always #1 clk = ~clk;

	multicore_task_list_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.tick_rate_we(tick_rate_we),
		.tick_rate_wdata(tick_rate_wdata)
	);

	// ------------------------------------------------------------------
	// Scheduler model state. Lists are indexed by kind minus one.
	// ------------------------------------------------------------------
	logic [15:0] rate_q;
	kind_t       kind_q [CORES][SLOTS];
	int          nxt_q [CORES][SLOTS];
	int          prv_q [CORES][SLOTS];
	logic [31:0] due_q [CORES][SLOTS];
	logic [31:0] msg_q [CORES][SLOTS];
	logic [7:0]  prio_q [CORES][SLOTS];
	int          head_q [CORES][3];
	int          tail_q [CORES][3];
	int          run_q [CORES];
	int          idle_q [CORES];
	logic [31:0] ticks_q [CORES];
	logic [15:0] idle_cnt_q [CORES];
	logic [15:0] frame_cnt_q [CORES];
	logic [15:0] snap_q [CORES];
	int          created_q [CORES];

	sched_result_t pending_results [$];
	int mismatches = 0;
	int send_gap_pct = 0;
	int recv_gap_pct = 0;
	int hold_requests = 0;

	function automatic void sched_clear();
		rate_q = 16'd1000;
		for (int c = 0; c < CORES; c++) begin
			for (int s = 0; s < SLOTS; s++) begin
				kind_q[c][s] = KIND_FREE;
				nxt_q[c][s] = NO_LINK;
				prv_q[c][s] = NO_LINK;
				due_q[c][s] = '0;
				msg_q[c][s] = '0;
				prio_q[c][s] = '0;
			end
			for (int l = 0; l < 3; l++) begin
				head_q[c][l] = NO_LINK;
				tail_q[c][l] = NO_LINK;
			end
			run_q[c] = NO_LINK;
			idle_q[c] = NO_LINK;
			ticks_q[c] = '0;
			idle_cnt_q[c] = '0;
			frame_cnt_q[c] = '0;
			snap_q[c] = '0;
			created_q[c] = 0;
		end
	endfunction

	function automatic void list_push(int c, kind_t k, int s);
		int l;
		int t;
		l = int'(k) - 1;
		t = tail_q[c][l];
		if (t != NO_LINK) begin
			nxt_q[c][t] = s;
			prv_q[c][s] = t;
		end else begin
			head_q[c][l] = s;
			prv_q[c][s] = NO_LINK;
		end
		tail_q[c][l] = s;
		nxt_q[c][s] = NO_LINK;
		kind_q[c][s] = k;
	endfunction

	function automatic void list_remove(int c, int s);
		int l;
		int p;
		int n;
		if (kind_q[c][s] == KIND_FREE) return;
		l = int'(kind_q[c][s]) - 1;
		p = prv_q[c][s];
		n = nxt_q[c][s];
		if (p != NO_LINK) nxt_q[c][p] = n;
		else head_q[c][l] = n;
		if (n != NO_LINK) prv_q[c][n] = p;
		else tail_q[c][l] = p;
		nxt_q[c][s] = NO_LINK;
		prv_q[c][s] = NO_LINK;
	endfunction

	// Round robin: successor in the running task's list, else the ready head.
	function automatic void pick_next(int c);
		int r;
		r = run_q[c];
		if (r < SLOTS && nxt_q[c][r] != NO_LINK) run_q[c] = nxt_q[c][r];
		else run_q[c] = head_q[c][int'(KIND_READY) - 1];
	endfunction

	// Applies one request to the model and returns the result it must give.
	function automatic sched_result_t schedule_step(logic [2:0] op, int c, logic [31:0] value,
			logic [7:0] prio, logic idle);
		sched_result_t res;
		int r;
		int s;
		int n;
		int cc;
		bit found;
		bit idle_now;
		int released;
		res = '0;
		res.status = ST_OK;
		released = 0;
		r = run_q[c];
		case (op)
			OP_CREATE: begin
				s = 0;
				while (s < SLOTS && kind_q[c][s] != KIND_FREE) s++;
				if (s >= SLOTS) begin
					res.status = ST_NO_SLOT;
				end else begin
					prio_q[c][s] = prio;
					created_q[c]++;
					if (r >= SLOTS) run_q[c] = s;
					if (idle) idle_q[c] = s;
					list_push(c, KIND_READY, s);
					res.slot = s[2:0];
				end
			end
			OP_DELAY, OP_WAIT: begin
				if (value == 0) begin
					res.status = ST_ZERO;
				end else if (r < SLOTS) begin
					list_remove(c, r);
					if (op == OP_DELAY) begin
						due_q[c][r] = ticks_q[c] + value;
						list_push(c, KIND_DELAYED, r);
					end else begin
						msg_q[c][r] = value;
						list_push(c, KIND_WAITING, r);
					end
					res.slot = r[2:0];
					pick_next(c);
				end
			end
			OP_RELEASE: begin
				if (value == 0) begin
					res.status = ST_ZERO;
				end else begin
					// Own core first, then the others in ascending order.
					found = 0;
					for (int i = 0; i <= CORES && !found; i++) begin
						cc = (i == 0) ? c : i - 1;
						if (i != 0 && cc == c) continue;
						s = head_q[cc][int'(KIND_WAITING) - 1];
						for (int k = 0; k < SLOTS && s < SLOTS && !found; k++) begin
							if (msg_q[cc][s] == value) begin
								list_remove(cc, s);
								list_push(cc, KIND_READY, s);
								res.slot = s[2:0];
								res.rel_core = cc[1:0];
								found = 1;
							end else begin
								s = nxt_q[cc][s];
							end
						end
					end
					if (!found) res.status = ST_NO_MATCH;
				end
			end
			OP_TICK: begin
				idle_now = (r < SLOTS) ? (r == idle_q[c]) : (idle_q[c] >= SLOTS);
				if (idle_now && idle_cnt_q[c] != 16'hFFFF) idle_cnt_q[c]++;
				if (frame_cnt_q[c] >= rate_q) begin
					frame_cnt_q[c] = '0;
					snap_q[c] = idle_cnt_q[c];
					idle_cnt_q[c] = '0;
				end else begin
					frame_cnt_q[c]++;
				end
				ticks_q[c]++;
				// Every due delayed task is released, in list order.
				s = head_q[c][int'(KIND_DELAYED) - 1];
				for (int k = 0; k < SLOTS && s < SLOTS; k++) begin
					n = nxt_q[c][s];
					if (ticks_q[c] >= due_q[c][s]) begin
						list_remove(c, s);
						list_push(c, KIND_READY, s);
						released++;
					end
					s = n;
				end
				pick_next(c);
			end
			OP_YIELD: pick_next(c);
			default: ;
		endcase
		r = run_q[c];
		res.cur_task = (r < SLOTS) ? r[2:0] : 3'd0;
		res.cur_valid = (r < SLOTS);
		res.count = created_q[c][3:0];
		if (rate_q == 0 || snap_q[c] >= rate_q) res.load = '0;
		else res.load = 7'(((32'(rate_q) - 32'(snap_q[c])) * PCT_SCALE) / 32'(rate_q));
		res.released = released[3:0];
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Drivers.
	// ------------------------------------------------------------------
	task automatic write_tick_rate(logic [15:0] v);
		@(posedge clk);
		tick_rate_we <= 1'b1;
		tick_rate_wdata <= v;
		@(posedge clk);
		tick_rate_we <= 1'b0;
		rate_q = v;
	endtask

	// Presents one item and returns at the edge where it is taken. Valid stays
	// high afterwards, so back-to-back items need no second assignment.
	task automatic offer_request(request_row_t req);
		sched_result_t want;
		if ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req.op;
		s_tdata <= {5'b0, req.idle, req.prio, req.value, req.core};
		do @(posedge clk); while (!s_tready);
		want = schedule_step(req.op, int'(req.core), req.value, req.prio, req.idle);
		pending_results.push_back(req.typed ? req.want : want);
	endtask

	task automatic drain_results();
		@(posedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Random requests: mostly small delays and message ids so tasks cycle
	// through all three lists; a few full-width and zero values.
	function automatic request_row_t random_request();
		request_row_t req;
		int pick;
		req = '{default: '0};
		pick = $urandom_range(99);
		if (pick < 8) req.op = OP_CREATE;
		else if (pick < 28) req.op = OP_DELAY;
		else if (pick < 46) req.op = OP_WAIT;
		else if (pick < 68) req.op = OP_RELEASE;
		else if (pick < 90) req.op = OP_TICK;
		else if (pick < 97) req.op = OP_YIELD;
		else req.op = 3'($urandom_range(7, 6));
		req.core = 2'($urandom_range(3));
		pick = $urandom_range(99);
		if (pick < 5) req.value = '0;
		else if (pick < 12) req.value = $urandom;
		else req.value = 32'($urandom_range(5, 1));
		req.prio = 8'($urandom);
		req.idle = ($urandom_range(7) == 0);
		return req;
	endfunction

	function automatic request_row_t drow(logic [2:0] op, logic [1:0] core, logic [31:0] value,
			logic [7:0] prio, logic idle, bit typed, status_t st, logic [2:0] slot,
			logic cv, logic [3:0] cnt);
		request_row_t req;
		req = '{op, core, value, prio, idle, typed, '0};
		req.want.status = st;
		req.want.slot = slot;
		req.want.cur_valid = cv;
		req.want.count = cnt;
		req.want.load = 7'd100;
		return req;
	endfunction

	// Receiver: random backpressure, or a long hold-off when the sender asks.
	int hold_seen = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		if (hold_requests != hold_seen) begin
			hold_seen = hold_requests;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// Result checker.
	always @(posedge clk) begin
		sched_result_t got;
		sched_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result item %h", m_tdata);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.slot !== want.slot
						|| got.rel_core !== want.rel_core || got.cur_task !== want.cur_task
						|| got.cur_valid !== want.cur_valid || got.count !== want.count
						|| got.load !== want.load || got.released !== want.released
						|| got.pad !== want.pad) begin
					mismatches++;
					if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	// Watchdog on cycles with no handshake on either channel.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_multicore_task_list_scheduler: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin
		request_row_t directed [$];
		sched_clear();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset every core is empty: delay and tick with no task, a
		// release that finds nothing, and a zero value that is ignored.
		directed.push_back(drow(OP_DELAY, 2'd1, 32'd5, 8'd0, 1'b0, 1, ST_OK, 3'd0, 1'b0, 4'd0));
		directed.push_back(drow(OP_TICK, 2'd1, 32'd0, 8'd0, 1'b0, 1, ST_OK, 3'd0, 1'b0, 4'd0));
		directed.push_back(drow(OP_RELEASE, 2'd2, 32'd7, 8'd0, 1'b0, 1, ST_NO_MATCH, 3'd0,
			1'b0, 4'd0));
		directed.push_back(drow(OP_WAIT, 2'd2, 32'd0, 8'd0, 1'b0, 1, ST_ZERO, 3'd0, 1'b0, 4'd0));
		directed.push_back(drow(OP_CREATE, 2'd0, 32'd0, 8'hFF, 1'b1, 1, ST_OK, 3'd0, 1'b1, 4'd1));
		// Fill core 0, then one create too many.
		for (int i = 1; i < SLOTS; i++)
			directed.push_back(drow(OP_CREATE, 2'd0, 32'hFFFF_FFFF, 8'(i * 37), i[0], 0, ST_OK,
				3'd0, 1'b0, 4'd0));
		directed.push_back(drow(OP_CREATE, 2'd0, 32'd0, 8'd0, 1'b0, 1, ST_NO_SLOT, 3'd0, 1'b1,
			4'd8));
		// Wait and release on the own core and across cores, full-width values.
		directed.push_back(drow(OP_WAIT, 2'd0, 32'hFFFF_FFFF, 8'd0, 1'b0, 0, ST_OK, 0, 0, 0));
		directed.push_back(drow(OP_CREATE, 2'd3, 32'd0, 8'h5A, 1'b0, 0, ST_OK, 0, 0, 0));
		directed.push_back(drow(OP_WAIT, 2'd3, 32'hA5A5_A5A5, 8'd0, 1'b0, 0, ST_OK, 0, 0, 0));
		directed.push_back(drow(OP_RELEASE, 2'd0, 32'hA5A5_A5A5, 8'd0, 1'b0, 0, ST_OK, 0, 0, 0));
		directed.push_back(drow(OP_RELEASE, 2'd0, 32'hFFFF_FFFF, 8'd0, 1'b0, 0, ST_OK, 0, 0, 0));
		directed.push_back(drow(OP_DELAY, 2'd0, 32'hFFFF_FFFF, 8'd0, 1'b0, 0, ST_OK, 0, 0, 0));
		directed.push_back(drow(OP_DELAY, 2'd0, 32'd1, 8'd0, 1'b0, 0, ST_OK, 0, 0, 0));
		directed.push_back(drow(OP_TICK, 2'd0, 32'd0, 8'd0, 1'b0, 0, ST_OK, 0, 0, 0));
		directed.push_back(drow(OP_YIELD, 2'd0, 32'd0, 8'd0, 1'b0, 0, ST_OK, 0, 0, 0));
		directed.push_back(drow(3'd6, 2'd0, 32'd9, 8'd0, 1'b0, 0, ST_OK, 0, 0, 0));
		directed.push_back(drow(3'd7, 2'd1, 32'd9, 8'd1, 1'b1, 0, ST_OK, 0, 0, 0));
		foreach (directed[i]) offer_request(directed[i]);
		drain_results();

		// Three random phases, each with its own rate and idling pattern.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					write_tick_rate(16'd1);
					send_gap_pct = 12;
					recv_gap_pct = 82;
				end
				1: begin
					write_tick_rate(16'hFFFF);
					send_gap_pct = 82;
					recv_gap_pct = 12;
				end
				default: begin
					write_tick_rate(16'd3);
					send_gap_pct = 0;
					recv_gap_pct = 0;
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Long result hold-off mid-phase: the block must fill and stall.
				if (phase == 2 && i == 200) hold_requests++;
				offer_request(random_request());
			end
			drain_results();
		end

		if (mismatches == 0)
			$display("tb_multicore_task_list_scheduler: done, clean");
		else
			$display("tb_multicore_task_list_scheduler: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+sv
sv/mtls_pkg.sv
sv/mtls_div.sv
sv/mtls_datapath.sv
sv/mtls_ctrl.sv
sv/multicore_task_list_scheduler.sv
sv/mtls_checker.sv
test/tb_multicore_task_list_scheduler.sv
